/* src/polynomial_extremum_bisection_unit_macros.svh */
// ----------------------------------------------------------------------------
// polynomial extremum bisection unit - assertion macros
// shared concurrent assertion shorthands, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_EXTREMUM_BISECTION_UNIT_MACROS_SVH
`define POLYNOMIAL_EXTREMUM_BISECTION_UNIT_MACROS_SVH

// same-cycle implication
`define PEB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define PEB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/peb_pkg.sv */
// ----------------------------------------------------------------------------
// peb_pkg
// types, constants and fixed-point helpers of the polynomial extremum unit
// ----------------------------------------------------------------------------
package peb_pkg;

  localparam int DATA_W         = 32;
  localparam int PROD_W         = 64;
  localparam int TOL_W          = 31;
  localparam int ITER_W         = 6;
  localparam int REG_IDX_W      = 3;
  localparam int DEF_MAX_DEGREE = 5;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(66);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(48);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5,
    REG_TOLERANCE, REG_MAX_ITERATIONS
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_FOUND, ST_NO_SIGN_CHANGE, ST_NOT_CONVERGED
  } status_t;

  typedef enum logic [1:0] {
    PT_LEFT, PT_RIGHT, PT_MID
  } point_t;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_MUL, S_DER, S_VAL, S_POST
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interval_low;
    logic signed [DATA_W-1:0] interval_high;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] extremum_x;
    status_t                  status;
    logic [ITER_W-1:0]        steps_used;
  } result_t;

  typedef struct packed {
    logic   load;
    logic   init_eval;
    point_t sel;
    logic   mul_der;
    logic   upd_der;
    logic   upd_val;
    logic   store_fl;
    logic   bisect;
    logic   finish;
    logic   zero_x;
  } dp_cmd_t;

  typedef struct packed {
    logic              der_same_fl;
    logic              der_within_tol;
    logic [ITER_W-1:0] iter_limit;
  } dp_status_t;

  // clamp a 64-bit value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat64(input logic signed [PROD_W-1:0] v);
    logic all_same;
    all_same = (&v[PROD_W-1:DATA_W-1]) | ~(|v[PROD_W-1:DATA_W-1]);
    if (all_same) begin
      return v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // saturating add of two 32-bit signed values
  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] == s[DATA_W-1]) begin
      return s[DATA_W-1:0];
    end else if (s[DATA_W]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // zero is a sign of its own
  function automatic logic same_sign(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
    logic az;
    logic bz;
    az = (a == '0);
    bz = (b == '0);
    return (az && bz) || (!az && !bz && (a[DATA_W-1] == b[DATA_W-1]));
  endfunction

endpackage

/* src/peb_datapath.sv */
// ----------------------------------------------------------------------------
// peb_datapath
// configuration registers, shared multiplier, horner accumulators, interval
// ----------------------------------------------------------------------------
module peb_datapath #(
  parameter int MAX_DEGREE = peb_pkg::DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = peb_pkg::DEF_FRAC_BITS,
  parameter int IDX_W      = $clog2(MAX_DEGREE + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_en,
  input  logic [peb_pkg::REG_IDX_W-1:0]     write_index,
  input  logic [peb_pkg::DATA_W-1:0]        write_data,
  input  peb_pkg::item_t                    item,
  input  peb_pkg::dp_cmd_t                  cmd,
  input  logic [IDX_W-1:0]                  idx,
  output peb_pkg::dp_status_t               stat,
  output logic signed [peb_pkg::DATA_W-1:0] extremum_x
);
  import peb_pkg::*;

  logic signed [DATA_W-1:0] coef [MAX_DEGREE+1];
  logic [TOL_W-1:0]         tolerance;
  logic [ITER_W-1:0]        max_iterations;

  logic signed [DATA_W-1:0] left, right, mid, fl, x, val, der;
  logic signed [PROD_W-1:0] prod;

  logic signed [DATA_W:0]   mid_sum;
  logic signed [DATA_W-1:0] midpoint;
  logic signed [DATA_W-1:0] point;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [DATA_W-1:0] fx_term;
  logic signed [DATA_W-1:0] acc_add;
  logic signed [DATA_W-1:0] acc;
  logic [DATA_W:0]          der_abs;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= MAX_DEGREE; i++) begin
        coef[i] <= '0;
      end
      tolerance      <= TOL_RESET;
      max_iterations <= ITER_RESET;
    end else if (write_en) begin
      for (int i = 0; i <= MAX_DEGREE; i++) begin
        if (write_index == REG_IDX_W'(i)) begin
          coef[i] <= write_data;
        end
      end
      if (write_index == REG_TOLERANCE) begin
        tolerance <= write_data[TOL_W-1:0];
      end
      if (write_index == REG_MAX_ITERATIONS) begin
        max_iterations <= write_data[ITER_W-1:0];
      end
    end
  end

  // floor of (left + right) / 2
  assign mid_sum  = {left[DATA_W-1], left} + {right[DATA_W-1], right};
  assign midpoint = mid_sum[DATA_W:1];

  always_comb begin
    case (cmd.sel)
      PT_LEFT:  point = left;
      PT_RIGHT: point = right;
      PT_MID:   point = midpoint;
      default:  point = midpoint;
    endcase
  end

  assign mul_a   = cmd.upd_der ? val : der;
  assign prod_sh = prod >>> FRAC_BITS;
  assign fx_term = sat64(prod_sh);
  assign acc_add = cmd.upd_der ? val : coef[idx];
  assign acc     = sat_add(fx_term, acc_add);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left  <= item.interval_low;
      right <= item.interval_high;
    end
    if (cmd.init_eval) begin
      x   <= point;
      val <= coef[MAX_DEGREE];
      der <= '0;
      if (cmd.sel == PT_MID) begin
        mid <= midpoint;
      end
    end
    if (cmd.mul_der || cmd.upd_der) begin
      prod <= mul_a * x;
    end
    if (cmd.upd_der) begin
      der <= acc;
    end
    if (cmd.upd_val) begin
      val <= acc;
    end
    if (cmd.store_fl) begin
      fl <= der;
    end
    if (cmd.bisect) begin
      if (stat.der_same_fl) begin
        left <= mid;
        fl   <= der;
      end else begin
        right <= mid;
      end
    end
    if (cmd.finish) begin
      extremum_x <= cmd.zero_x ? '0 : mid;
    end
  end

  assign der_abs = der[DATA_W-1] ? -{der[DATA_W-1], der} : {1'b0, der};

  assign stat.der_same_fl    = same_sign(der, fl);
  assign stat.der_within_tol = (der_abs <= {2'b00, tolerance});
  assign stat.iter_limit     = max_iterations;

endmodule

/* src/peb_ctrl.sv */
// ----------------------------------------------------------------------------
// peb_ctrl
// sequencer: horner passes at the ends and midpoints, bisection decisions
// ----------------------------------------------------------------------------
`include "polynomial_extremum_bisection_unit_macros.svh"

module peb_ctrl #(
  parameter int MAX_DEGREE = peb_pkg::DEF_MAX_DEGREE,
  parameter int IDX_W      = $clog2(MAX_DEGREE + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  peb_pkg::dp_status_t           stat,
  output peb_pkg::dp_cmd_t              cmd,
  output logic [IDX_W-1:0]              idx,
  output logic                          done,
  output peb_pkg::status_t              status,
  output logic [peb_pkg::ITER_W-1:0]    steps_used
);
  import peb_pkg::*;

  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_DEGREE - 1);

  state_t            state, state_next;
  point_t            pt, pt_next;
  logic [IDX_W-1:0]  idx_next;
  logic [ITER_W-1:0] steps, steps_next;
  logic              finish;
  status_t           fin_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pt    <= PT_LEFT;
      idx   <= IDX_TOP;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pt    <= pt_next;
      idx   <= idx_next;
      steps <= steps_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status     <= fin_status;
      steps_used <= steps;
    end
  end

  always_comb begin
    state_next = state;
    pt_next    = pt;
    idx_next   = idx;
    steps_next = steps;
    finish     = 1'b0;
    fin_status = ST_FOUND;
    cmd        = '0;
    cmd.sel    = pt;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          pt_next    = PT_LEFT;
          steps_next = '0;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_eval = 1'b1;
        idx_next      = IDX_TOP;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_der = 1'b1;
        state_next  = S_DER;
      end
      S_DER: begin
        cmd.upd_der = 1'b1;
        state_next  = S_VAL;
      end
      S_VAL: begin
        cmd.upd_val = 1'b1;
        if (idx == '0) begin
          state_next = S_POST;
        end else begin
          idx_next   = idx - 1'b1;
          state_next = S_MUL;
        end
      end
      S_POST: begin
        case (pt)
          PT_LEFT: begin
            cmd.store_fl = 1'b1;
            pt_next      = PT_RIGHT;
            state_next   = S_INIT;
          end
          PT_RIGHT: begin
            if (stat.der_same_fl) begin
              finish     = 1'b1;
              fin_status = ST_NO_SIGN_CHANGE;
              cmd.finish = 1'b1;
              cmd.zero_x = 1'b1;
              state_next = S_IDLE;
            end else begin
              pt_next    = PT_MID;
              state_next = S_INIT;
            end
          end
          default: begin
            if (stat.der_within_tol) begin
              finish     = 1'b1;
              fin_status = ST_FOUND;
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end else if (steps >= stat.iter_limit) begin
              finish     = 1'b1;
              fin_status = ST_NOT_CONVERGED;
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.bisect = 1'b1;
              steps_next = steps + 1'b1;
              state_next = S_INIT;
            end
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  `PEB_ASSERT_SAME(a_done_idle, clk, rst, done, state == S_IDLE)
  `PEB_ASSERT_NEXT(a_start_left, clk, rst, start && !busy,
                   state == S_INIT && pt == PT_LEFT && steps == '0)
  `PEB_ASSERT_SAME(a_nosign_zero, clk, rst, done && status == ST_NO_SIGN_CHANGE,
                   steps_used == '0)
  `PEB_ASSERT_SAME(a_steps_bound, clk, rst, busy, steps <= stat.iter_limit)
  `PEB_ASSERT_SAME(a_notconv_limit, clk, rst, finish && fin_status == ST_NOT_CONVERGED,
                   steps == stat.iter_limit)

endmodule

/* src/polynomial_extremum_bisection_unit.sv */
// ----------------------------------------------------------------------------
// polynomial_extremum_bisection_unit
// extremum of a degree-five polynomial by bisection on its derivative sign
// ----------------------------------------------------------------------------
// Pulse start with an interval while busy is low; one result follows, shown
// for a single cycle with done high, and must be captured then since the
// receiver cannot stall it. Every derivative evaluation is a Horner pass on
// one shared 32x32 multiplier: multiply, derivative update and value update
// per coefficient, after a set-up step and before a decision step. An item
// takes one evaluation at each end and then one per midpoint, two in all when
// the ends show no sign change; the default limit is 48 bisection steps. The
// result strobe comes in the cycle after the last evaluation's decision, and
// busy drops in the same cycle, so the next item may start while done is high.
// ----------------------------------------------------------------------------
module polynomial_extremum_bisection_unit #(
  parameter int MAX_DEGREE = peb_pkg::DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = peb_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  peb_pkg::item_t                item,
  output logic                          done,
  output peb_pkg::result_t              result,
  input  logic                          write_en,
  input  logic [peb_pkg::REG_IDX_W-1:0] write_index,
  input  logic [peb_pkg::DATA_W-1:0]    write_data
);
  import peb_pkg::*;

  localparam int IDX_W = $clog2(MAX_DEGREE + 1);

  dp_cmd_t           cmd;
  dp_status_t        stat;
  logic [IDX_W-1:0]  idx;
  status_t           res_status;
  logic [ITER_W-1:0] res_steps;
  logic signed [DATA_W-1:0] res_x;

  peb_ctrl #(
    .MAX_DEGREE (MAX_DEGREE),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .stat       (stat),
    .cmd        (cmd),
    .idx        (idx),
    .done       (done),
    .status     (res_status),
    .steps_used (res_steps)
  );

  peb_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .item        (item),
    .cmd         (cmd),
    .idx         (idx),
    .stat        (stat),
    .extremum_x  (res_x)
  );

  assign result.extremum_x = res_x;
  assign result.status     = res_status;
  assign result.steps_used = res_steps;

endmodule

/* tb/polynomial_extremum_bisection_unit_tb.sv */
// ----------------------------------------------------------------------------
// polynomial_extremum_bisection_unit_tb
// self-checking bench for the bisection search of a polynomial extremum
// ----------------------------------------------------------------------------
// A short table of register writes and intervals opens the run. Randomly
// configured phases of random intervals follow. Each accepted interval beat
// without a typed expectation is scored by a local model of the joint Horner
// pass and the bisection loop, and each result beat is matched in order, field
// by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module polynomial_extremum_bisection_unit_tb;
  import peb_pkg::*;

  localparam int WATCHDOG_LIMIT  = 8000;
  localparam int NUM_PHASES      = 15;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int FRAC            = DEF_FRAC_BITS;
  localparam int PRINT_LIMIT     = 40;

  localparam logic signed [DATA_W-1:0] ONE      = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] SPAN_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] SPAN_MAX = 32'sh7FFF_FFFF;
  localparam longint                   SAT_HI   = 64'sh7FFF_FFFF;
  localparam longint                   SAT_LO   = -64'sh8000_0000;

  typedef struct {
    bit                is_write;
    reg_idx_t          reg_sel;
    logic [DATA_W-1:0] reg_data;
    item_t             span;
    bit                typed;
    result_t           want;
  } script_row_t;

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 start       = 1'b0;
  logic                 busy;
  item_t                item        = '0;
  logic                 done;
  result_t              result;
  logic                 write_en    = 1'b0;
  logic [REG_IDX_W-1:0] write_index = '0;
  logic [DATA_W-1:0]    write_data  = '0;

  // local copy of the register file
  logic signed [DATA_W-1:0] poly_coef [6];
  logic [TOL_W-1:0]         stop_tol;
  logic [ITER_W-1:0]        step_limit;

  result_t     pending_results [$];
  script_row_t script [30];
  int          error_count    = 0;
  int          beats_in       = 0;
  int          beats_out      = 0;
  int          status_seen [3] = '{0, 0, 0};
  int          idle_cycles    = 0;

  polynomial_extremum_bisection_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // longint is signed, so the arithmetic shift rounds toward minus infinity
  function automatic longint fx_product(input longint a, input longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> FRAC);
  endfunction

  function automatic int sign_of(input longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // value and slope carried together through one Horner pass
  function automatic longint slope_at(input longint x);
    longint v;
    longint d;
    v = poly_coef[5];
    d = 0;
    for (int i = 4; i >= 0; i--) begin
      d = clamp32(fx_product(d, x) + v);
      v = clamp32(fx_product(v, x) + longint'(poly_coef[i]));
    end
    return d;
  endfunction

  function automatic result_t predict_extremum(input item_t it);
    result_t r;
    longint  lo;
    longint  hi;
    longint  mid;
    longint  f_lo;
    longint  f_hi;
    longint  f_mid;
    int      steps;
    lo           = it.interval_low;
    hi           = it.interval_high;
    f_lo         = slope_at(lo);
    f_hi         = slope_at(hi);
    r.extremum_x = '0;
    r.status     = ST_NO_SIGN_CHANGE;
    r.steps_used = '0;
    if (sign_of(f_lo) == sign_of(f_hi)) return r;
    mid      = (lo + hi) >>> 1;
    f_mid    = slope_at(mid);
    steps    = 0;
    r.status = ST_FOUND;
    while ((f_mid < 0 ? -f_mid : f_mid) > longint'(stop_tol)) begin
      if (steps >= int'(step_limit)) begin
        r.status = ST_NOT_CONVERGED;
        break;
      end
      // keep the half whose ends disagree in sign
      if (sign_of(f_mid) == sign_of(f_lo)) begin
        lo   = mid;
        f_lo = f_mid;
      end else begin
        hi = mid;
      end
      mid   = (lo + hi) >>> 1;
      f_mid = slope_at(mid);
      steps++;
    end
    r.extremum_x = DATA_W'(mid);
    r.steps_used = ITER_W'(steps);
    return r;
  endfunction

  function automatic script_row_t set_reg_row(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    script_row_t row;
    row.is_write = 1'b1;
    row.reg_sel  = idx;
    row.reg_data = data;
    row.span     = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic script_row_t check_row(input logic signed [DATA_W-1:0] lo,
                                            input logic signed [DATA_W-1:0] hi);
    script_row_t row;
    row.is_write           = 1'b0;
    row.reg_sel            = REG_COEF_0;
    row.reg_data           = '0;
    row.typed              = 1'b0;
    row.want               = '0;
    row.span.interval_low  = lo;
    row.span.interval_high = hi;
    return row;
  endfunction

  function automatic script_row_t typed_row(input logic signed [DATA_W-1:0] lo,
                                            input logic signed [DATA_W-1:0] hi,
                                            input logic signed [DATA_W-1:0] x,
                                            input status_t st,
                                            input int n);
    script_row_t row;
    row                 = check_row(lo, hi);
    row.typed           = 1'b1;
    row.want.extremum_x = x;
    row.want.status     = st;
    row.want.steps_used = ITER_W'(n);
    return row;
  endfunction

  function automatic logic [DATA_W-1:0] draw_coef();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return '0;
    if (pick < 70) return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    if (pick < 85) return $urandom_range(0, 32'h200_0000) - 32'h100_0000;
    if (pick < 95) return $urandom();
    return pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  // the first phases pin the extreme settings, the rest are drawn
  function automatic logic [DATA_W-1:0] draw_reg_value(input reg_idx_t idx, input int phase);
    logic [DATA_W-1:0] data;
    logic [TOL_W-1:0]  tol;
    int unsigned       pick;
    data = $urandom();
    pick = $urandom_range(0, 9);
    case (idx)
      REG_TOLERANCE: begin
        if (phase == 0 || pick == 0) tol = '0;
        else if (phase == 1 || pick == 1) tol = '1;
        else if (pick < 6) tol = TOL_W'($urandom_range(0, 4096));
        else tol = TOL_W'($urandom());
        data[TOL_W-1:0] = tol;
      end
      REG_MAX_ITERATIONS: begin
        if (phase == 0 || pick == 0) data[ITER_W-1:0] = '1;
        else if (phase == 1 || pick == 1) data[ITER_W-1:0] = '0;
        else if (phase == 2 || pick == 2) data[ITER_W-1:0] = ITER_W'(1);
        else data[ITER_W-1:0] = ITER_W'($urandom_range(2, 48));
      end
      default: data = draw_coef();
    endcase
    return data;
  endfunction

  function automatic item_t draw_interval();
    item_t                    it;
    int unsigned              pick;
    logic signed [DATA_W-1:0] swap;
    logic signed [DATA_W-1:0] corners [5];
    corners = '{SPAN_MIN, SPAN_MAX, '0, -32'sd1, 32'sd1};
    pick    = $urandom_range(0, 99);
    if (pick < 55) begin
      // mostly straddling the origin, where small polynomials turn
      it.interval_low  = $urandom_range(0, 32'h6_0000) - 32'h5_0000;
      it.interval_high = $urandom_range(0, 32'h6_0000) - 32'h1_0000;
    end else if (pick < 70) begin
      it.interval_low  = $urandom_range(0, 32'h200_0000) - 32'h200_0000;
      it.interval_high = $urandom_range(0, 32'h200_0000);
    end else if (pick < 85) begin
      it.interval_low  = $urandom();
      it.interval_high = $urandom();
    end else if (pick < 95) begin
      it.interval_low  = corners[$urandom_range(0, 4)];
      it.interval_high = corners[$urandom_range(0, 4)];
    end else begin
      it.interval_low  = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      it.interval_high = it.interval_low;
    end
    if ($urandom_range(0, 6) == 0) begin
      swap             = it.interval_low;
      it.interval_low  = it.interval_high;
      it.interval_high = swap;
    end
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (error_count < PRINT_LIMIT) begin
      $display("mismatch @%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    error_count++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    write_en    <= 1'b1;
    write_index <= idx;
    write_data  <= data;
    @(posedge clk);
    write_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TOLERANCE:      stop_tol   = data[TOL_W-1:0];
      REG_MAX_ITERATIONS: step_limit = data[ITER_W-1:0];
      default:            poly_coef[idx] = data;
    endcase
  endtask

  // hold off the sender until every outstanding result beat has come back
  task automatic drain_results();
    if (start) start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_interval(input item_t it, input bit typed, input result_t want,
                               input bit pace);
    int gap;
    gap = pace ? $urandom_range(0, 6) : 0;
    // start stays high across back-to-back beats
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    pending_results.insert(pending_results.size(), typed ? want : predict_extremum(it));
    beats_in++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding", result.extremum_x, 0);
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (result.extremum_x !== want.extremum_x)
          flag_mismatch("extremum_x", result.extremum_x, want.extremum_x);
        if (result.status !== want.status)
          flag_mismatch("status", result.status, want.status);
        if (result.steps_used !== want.steps_used)
          flag_mismatch("steps_used", result.steps_used, want.steps_used);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    result_t leftover;
    poly_coef  = '{default: '0};
    stop_tol   = TOL_RESET;
    step_limit = ITER_RESET;

    script = '{
      // all coefficients zero after reset: flat slope at both ends
      typed_row(SPAN_MIN, SPAN_MAX, '0, ST_NO_SIGN_CHANGE, 0),
      typed_row('0, '0, '0, ST_NO_SIGN_CHANGE, 0),
      typed_row(SPAN_MAX, SPAN_MIN, '0, ST_NO_SIGN_CHANGE, 0),
      typed_row(-32'sd1, 32'sd1, '0, ST_NO_SIGN_CHANGE, 0),
      // x^2 - 2x, slope 2x - 2, turning point at 1.0
      set_reg_row(REG_COEF_2, ONE),
      set_reg_row(REG_COEF_1, -2 * ONE),
      typed_row('0, 2 * ONE, ONE, ST_FOUND, 0),
      check_row('0, 4 * ONE),
      check_row(4 * ONE, '0),
      check_row(SPAN_MIN, SPAN_MAX),
      typed_row(ONE, ONE, '0, ST_NO_SIGN_CHANGE, 0),
      // zero slope exactly at one end
      check_row(ONE, 3 * ONE),
      check_row(-3 * ONE, ONE),
      set_reg_row(REG_MAX_ITERATIONS, '0),
      typed_row('0, 4 * ONE, 2 * ONE, ST_NOT_CONVERGED, 0),
      set_reg_row(REG_MAX_ITERATIONS, 32'd1),
      set_reg_row(REG_TOLERANCE, '0),
      check_row('0, 3 * ONE),
      set_reg_row(REG_TOLERANCE, 32'h7FFF_FFFF),
      typed_row('0, 4 * ONE, 2 * ONE, ST_FOUND, 0),
      set_reg_row(REG_MAX_ITERATIONS, 32'd63),
      set_reg_row(REG_TOLERANCE, '0),
      // saturating Horner terms
      set_reg_row(REG_COEF_5, 32'h7FFF_FFFF),
      set_reg_row(REG_COEF_0, 32'h8000_0000),
      check_row(SPAN_MIN, SPAN_MAX),
      check_row(-ONE, ONE / 2),
      set_reg_row(REG_COEF_3, 32'h8000_0000),
      set_reg_row(REG_COEF_4, 32'h0000_0001),
      check_row(SPAN_MIN, '0),
      check_row(-ONE, ONE)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_write) begin
        drain_results();
        write_reg(script[i].reg_sel, script[i].reg_data);
      end else begin
        send_interval(script[i].span, script[i].typed, script[i].want, 1'b1);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      bit pace;
      drain_results();
      for (int r = 0; r <= int'(REG_MAX_ITERATIONS); r++) begin
        write_reg(reg_idx_t'(r), draw_reg_value(reg_idx_t'(r), phase));
      end
      // some phases run the sender flat out
      pace = ($urandom_range(0, 3) != 0);
      repeat (ITEMS_PER_PHASE) send_interval(draw_interval(), 1'b0, '0, pace);
    end

    drain_results();
    repeat (40) @(posedge clk);
    while (pending_results.size() != 0) begin
      leftover = pending_results.pop_front();
      flag_mismatch("result beat never arrived", 0, leftover.extremum_x);
    end

    $display("run covered %0d interval beats, %0d result beats, %0d register settings",
             beats_in, beats_out, NUM_PHASES + 1);
    $display("outcomes: %0d found, %0d without sign change, %0d out of steps",
             status_seen[ST_FOUND], status_seen[ST_NO_SIGN_CHANGE],
             status_seen[ST_NOT_CONVERGED]);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
